/* rtl/core/rpp_pkg.sv */
`timescale 1ns / 1ps

package rpp_pkg;

  typedef enum logic [1:0] {
    MODE_BYPASS    = 2'd0,
    MODE_GRAY      = 2'd1,
    MODE_THRESHOLD = 2'd2,
    MODE_INVERT    = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [1:0] MODE_RESET      = 2'd0;
  localparam logic [7:0] THRESHOLD_RESET = 8'd128;

  // Luma weights, scaled by 1000
  localparam logic [8:0] W_RED   = 9'd281;
  localparam logic [9:0] W_GREEN = 10'd562;
  localparam logic [6:0] W_BLUE  = 7'd93;

  // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x up to 29016
  localparam logic [15:0] RECIP       = 16'd33555;
  localparam int          RECIP_SHIFT = 25;

  localparam logic [9:0]  CHAN_MAX8_X3 = 10'd765;
  localparam logic [15:0] WHITE_555    = 16'h7FFF;

  typedef struct packed {
    logic [15:0] raw;
    logic [13:0] w_red;
    logic [14:0] w_green;
    logic [11:0] w_blue;
    logic [4:0]  inv;
  } prod_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [14:0] sum;
    logic [4:0]  inv;
  } sum_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [4:0]  gray;
    logic [4:0]  inv;
  } gray_t;

endpackage

/* rtl/core/rgb555_pixel_preprocess.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake                Payload
// s_axis    in   tvalid / tready          tdata[15:0] pixel_in
// m_axis    out  tvalid / tready          tdata[15:0] pixel_out
// cfg       in   cfg_valid / cfg_ready    cfg_index (0 mode, 1 threshold_level), cfg_data
//
// One pixel per clock sustained while m_axis_tready_i is high. The four stages are:
// channel unpack and constant products, weighted sum, reciprocal multiply for the
// divide by 1000, and mode select / output register, each holding its own register.
// Reset clears the valid bits and loads mode = bypass, threshold_level = 128.
// Each stage moves when it is empty or the next one takes its request, so a
// stalled output fills the bubbles upstream before s_axis_tready_o drops.

module rgb555_pixel_preprocess (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // pixel in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] pixel_in
  // pixel out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] pixel_out
);

  rpp_pkg::mode_e  mode_q;
  logic [7:0]      threshold_q;

  logic            prod_vld, prod_rdy;
  rpp_pkg::prod_t  prod_data;
  logic            gray_vld, gray_rdy;
  rpp_pkg::gray_t  gray_data;

  // Registers are always writable; the user must write only while the pipe is empty, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= rpp_pkg::mode_e'(rpp_pkg::MODE_RESET);
      threshold_q <= rpp_pkg::THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rpp_pkg::CFG_MODE:      mode_q      <= rpp_pkg::mode_e'(cfg_data_i[1:0]);
        rpp_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: split channels, multiply by luma weights, invert sum
  rpp_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .pixel_i (s_axis_tdata_i),
    .valid_o (prod_vld),
    .ready_i (prod_rdy),
    .data_o  (prod_data)
  );

  // Stages 2-3: weighted sum, then floor division by 1000
  rpp_gray u_gray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_vld),
    .ready_o (prod_rdy),
    .data_i  (prod_data),
    .valid_o (gray_vld),
    .ready_i (gray_rdy),
    .data_o  (gray_data)
  );

  // Stage 4: mode select into the output register
  rpp_format u_format (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .threshold_i (threshold_q),
    .valid_i     (gray_vld),
    .ready_o     (gray_rdy),
    .data_i      (gray_data),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .pixel_o     (m_axis_tdata_o)
  );

endmodule

/* rtl/core/rpp_unpack.sv */
`timescale 1ns / 1ps

module rpp_unpack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [15:0]          pixel_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rpp_pkg::prod_t       data_o
);

  logic            vld_q;
  rpp_pkg::prod_t  data_d, data_q;
  logic [4:0]      r, g, b;
  logic [6:0]      chan_sum;

  assign b = pixel_i[4:0];
  assign g = pixel_i[9:5];
  assign r = pixel_i[14:10];
  assign chan_sum = 7'(r) + 7'(g) + 7'(b);

  always_comb begin
    data_d.raw     = pixel_i;
    data_d.w_red   = 14'(r) * 14'(rpp_pkg::W_RED);
    data_d.w_green = 15'(g) * 15'(rpp_pkg::W_GREEN);
    data_d.w_blue  = 12'(b) * 12'(rpp_pkg::W_BLUE);
    // low five bits of 765 - (r+g+b)
    data_d.inv     = 5'(rpp_pkg::CHAN_MAX8_X3) - chan_sum[4:0];
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/rpp_gray.sv */
`timescale 1ns / 1ps

module rpp_gray (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rpp_pkg::prod_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rpp_pkg::gray_t  data_o
);

  // stage A: weighted sum
  logic           sum_vld_q;
  logic           sum_ready;
  rpp_pkg::sum_t  sum_d, sum_q;
  // stage B: divide by 1000 through the reciprocal
  logic           gray_vld_q;
  rpp_pkg::gray_t gray_d, gray_q;
  logic [30:0]    prod;

  always_comb begin
    sum_d.raw = data_i.raw;
    sum_d.sum = 15'(data_i.w_red) + data_i.w_green + 15'(data_i.w_blue);
    sum_d.inv = data_i.inv;
  end

  assign prod = 31'(sum_q.sum) * 31'(rpp_pkg::RECIP);

  always_comb begin
    gray_d.raw  = sum_q.raw;
    gray_d.gray = prod[rpp_pkg::RECIP_SHIFT +: 5];
    gray_d.inv  = sum_q.inv;
  end

  assign ready_o   = !sum_vld_q || sum_ready;
  assign sum_ready = !gray_vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q  <= 1'b0;
      gray_vld_q <= 1'b0;
    end else begin
      if (ready_o) begin
        sum_vld_q <= valid_i;
      end
      if (sum_ready) begin
        gray_vld_q <= sum_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sum_q <= sum_d;
    end
    if (sum_ready && sum_vld_q) begin
      gray_q <= gray_d;
    end
  end

  assign valid_o = gray_vld_q;
  assign data_o  = gray_q;

endmodule

/* rtl/core/rpp_format.sv */
`timescale 1ns / 1ps

module rpp_format (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rpp_pkg::mode_e  mode_i,
  input  logic [7:0]      threshold_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  rpp_pkg::gray_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [15:0]     pixel_o
);

  logic        vld_q;
  logic [15:0] pix_d, pix_q;
  logic [7:0]  gray_x8;

  assign gray_x8 = {data_i.gray, 3'b000};

  always_comb begin
    case (mode_i)
      rpp_pkg::MODE_BYPASS:    pix_d = data_i.raw;
      rpp_pkg::MODE_GRAY:      pix_d = {1'b0, data_i.gray, data_i.gray, data_i.gray};
      rpp_pkg::MODE_THRESHOLD: pix_d = (gray_x8 < threshold_i) ? 16'h0000
                                                               : rpp_pkg::WHITE_555;
      rpp_pkg::MODE_INVERT:    pix_d = {1'b0, data_i.inv, data_i.inv, data_i.inv};
      default:                 pix_d = data_i.raw;
    endcase
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = vld_q;
  assign pixel_o = pix_q;

endmodule

/* dv/rgb555_pixel_preprocess_test.sv */
`timescale 1ns / 1ps

module rgb555_pixel_preprocess_test;

  // ---------------------------------------------------------------------------
  // Clock, reset and the ports of the block
  // ---------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = rpp_pkg::CFG_MODE;
  logic [7:0]  cfg_data  = 8'd0;
  logic        s_tvalid  = 1'b0;
  logic [15:0] s_tdata   = 16'd0;
  logic        m_tready  = 1'b0;

  logic        cfg_ready;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;

  rgb555_pixel_preprocess u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [15:0] pixel_in
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [15:0] pixel_out
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop; the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("rgb555_pixel_preprocess_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel predictor and the store of pixels still owed by the block
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [15:0]    pixel_in;
    rpp_pkg::mode_e mode;
    logic [15:0]    want;
  } owed_pixel_t;

  owed_pixel_t out_pixels_due[$];

  // Settings as the block holds them; follow every accepted register write.
  rpp_pkg::mode_e cur_mode  = rpp_pkg::MODE_BYPASS;
  logic [7:0]     cur_level = 8'd128;

  int error_count     = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int per_mode [4]    = '{0, 0, 0, 0};
  bit src_calm        = 1'b0;
  bit sink_calm       = 1'b0;

  function automatic logic [15:0] preprocess_pixel(input logic [15:0] px,
                                                   input rpp_pkg::mode_e mode,
                                                   input logic [7:0] level);
    int unsigned r, g, b, luma;
    logic [7:0]  luma_x8;
    logic [9:0]  inv_sum;
    logic [4:0]  shade;
    b = px[4:0];
    g = px[9:5];
    r = px[14:10];
    // Exact integer form of 0.281 r + 0.562 g + 0.093 b, rounded down
    luma = (281 * r + 562 * g + 93 * b) / 1000;
    case (mode)
      rpp_pkg::MODE_BYPASS: begin
        return px;
      end
      rpp_pkg::MODE_GRAY: begin
        shade = luma[4:0];
        return {1'b0, shade, shade, shade};
      end
      rpp_pkg::MODE_THRESHOLD: begin
        luma_x8 = 8'(luma * 8);
        return (luma_x8 < level) ? 16'h0000 : rpp_pkg::WHITE_555;
      end
      default: begin
        // Sum of the three 8-bit inverted channels, low five bits only
        inv_sum = 10'(765 - (r + g + b));
        shade   = inv_sum[4:0];
        return {1'b0, shade, shade, shade};
      end
    endcase
  endfunction

  task automatic report_error(input string msg);
    if (error_count < 30) $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Idle length: mostly none or a short one, now and then a long one.
  // Calm stretches run with no idling at all.
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random back pressure, each result checked against the oldest
  // owed pixel
  // ---------------------------------------------------------------------------
  initial begin
    int          hold;
    owed_pixel_t owed;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) begin
        if (out_pixels_due.size() == 0) begin
          report_error($sformatf("pixel_out %h with no request outstanding", m_tdata));
        end else begin
          owed = out_pixels_due.pop_front();
          results_checked++;
          if (m_tdata !== owed.want)
            report_error($sformatf("pixel_out %h, want %h (pixel_in %h, %s)",
                                   m_tdata, owed.want, owed.pixel_in, owed.mode.name()));
        end
      end
      if ($urandom_range(149) == 0) sink_calm = !sink_calm;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap(sink_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One pixel request. tvalid stays high into the next call when it has no gap.
  task automatic send_pixel(input logic [15:0] px, input logic known, input logic [15:0] want);
    int          gap;
    owed_pixel_t owed;
    gap = pick_gap(src_calm);
    if ($urandom_range(199) == 0) src_calm = !src_calm;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    owed.pixel_in = px;
    owed.mode     = cur_mode;
    owed.want     = known ? want : preprocess_pixel(px, cur_mode, cur_level);
    out_pixels_due.push_back(owed);
    pixels_sent++;
    per_mode[cur_mode]++;
  endtask

  // Stop sending and wait for every owed pixel, then idle on further so the
  // pipeline is empty before a register changes.
  task automatic settle_pipeline();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (out_pixels_due.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (out_pixels_due.size() != 0) begin
      report_error($sformatf("%0d pixels never came out", out_pixels_due.size()));
      out_pixels_due.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rpp_pkg::CFG_MODE) cur_mode = rpp_pkg::mode_e'(data[1:0]);
    else cur_level = data;
    reg_writes++;
    @(posedge clk);
  endtask

  // Mode writes carry junk in the unused upper bits.
  task automatic apply_settings(input rpp_pkg::mode_e mode, input logic [7:0] level);
    settle_pipeline();
    write_reg(rpp_pkg::CFG_MODE, {6'($urandom), 2'(mode)});
    write_reg(rpp_pkg::CFG_THRESHOLD, level);
  endtask

  function automatic logic [15:0] random_pixel();
    logic [4:0] chan [3];
    if ($urandom_range(9) < 4) return 16'($urandom);
    foreach (chan[i]) begin
      case ($urandom_range(3))
        0:       chan[i] = 5'd0;
        1:       chan[i] = 5'd31;
        default: chan[i] = 5'($urandom);
      endcase
    end
    return {1'($urandom), chan[2], chan[1], chan[0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: settings, pixel, and the result where it is plain to see
  // ---------------------------------------------------------------------------
  typedef struct packed {
    rpp_pkg::mode_e mode;
    logic [7:0]     level;
    logic [15:0]    pixel;
    logic           known;
    logic [15:0]    want;
  } directed_row_t;

  localparam int NUM_ROWS = 22;

  directed_row_t directed_rows [NUM_ROWS] = '{
    // reset settings: bypass, bit 15 passes through
    '{rpp_pkg::MODE_BYPASS,    8'd128, 16'h0000, 1'b1, 16'h0000},
    '{rpp_pkg::MODE_BYPASS,    8'd128, 16'hFFFF, 1'b1, 16'hFFFF},
    '{rpp_pkg::MODE_BYPASS,    8'd128, 16'h8000, 1'b1, 16'h8000},
    '{rpp_pkg::MODE_BYPASS,    8'd128, 16'h7FFF, 1'b1, 16'h7FFF},
    // grayscale: black, full white (gray 29), bit 15 dropped, single channels
    '{rpp_pkg::MODE_GRAY,      8'd128, 16'h0000, 1'b1, 16'h0000},
    '{rpp_pkg::MODE_GRAY,      8'd128, 16'h7FFF, 1'b1, 16'h77BD},
    '{rpp_pkg::MODE_GRAY,      8'd128, 16'hFFFF, 1'b1, 16'h77BD},
    '{rpp_pkg::MODE_GRAY,      8'd128, 16'h7C00, 1'b0, 16'h0000},
    '{rpp_pkg::MODE_GRAY,      8'd128, 16'h03E0, 1'b0, 16'h0000},
    '{rpp_pkg::MODE_GRAY,      8'd128, 16'h001F, 1'b0, 16'h0000},
    // threshold at reset level, then at both ends and around gray*8 = 232
    '{rpp_pkg::MODE_THRESHOLD, 8'd128, 16'h0000, 1'b1, 16'h0000},
    '{rpp_pkg::MODE_THRESHOLD, 8'd128, 16'h7FFF, 1'b1, 16'h7FFF},
    '{rpp_pkg::MODE_THRESHOLD, 8'd128, 16'h4210, 1'b0, 16'h0000},
    '{rpp_pkg::MODE_THRESHOLD, 8'd0,   16'h0000, 1'b1, 16'h7FFF},
    '{rpp_pkg::MODE_THRESHOLD, 8'd255, 16'h7FFF, 1'b1, 16'h0000},
    '{rpp_pkg::MODE_THRESHOLD, 8'd232, 16'h7FFF, 1'b1, 16'h7FFF},
    '{rpp_pkg::MODE_THRESHOLD, 8'd233, 16'h7FFF, 1'b1, 16'h0000},
    // invert is a summed value mod 32, not per channel
    '{rpp_pkg::MODE_INVERT,    8'd233, 16'h0000, 1'b1, 16'h77BD},
    '{rpp_pkg::MODE_INVERT,    8'd233, 16'h7FFF, 1'b1, 16'h0000},
    '{rpp_pkg::MODE_INVERT,    8'd233, 16'hFFFF, 1'b1, 16'h0000},
    '{rpp_pkg::MODE_INVERT,    8'd233, 16'h0001, 1'b0, 16'h0000},
    '{rpp_pkg::MODE_INVERT,    8'd233, 16'h5A5A, 1'b0, 16'h0000}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_PIXELS  = 150;

  initial begin
    rpp_pkg::mode_e mode;
    logic [7:0]     level;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part; registers change only where the row asks for it
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != cur_mode || directed_rows[i].level != cur_level) begin
        settle_pipeline();
        if (directed_rows[i].mode != cur_mode)
          write_reg(rpp_pkg::CFG_MODE, {6'd0, 2'(directed_rows[i].mode)});
        if (directed_rows[i].level != cur_level)
          write_reg(rpp_pkg::CFG_THRESHOLD, directed_rows[i].level);
      end
      send_pixel(directed_rows[i].pixel, directed_rows[i].known, directed_rows[i].want);
    end

    // Random part: each phase a fresh setting, every mode covered early
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = (p < 4) ? rpp_pkg::mode_e'(p) : rpp_pkg::mode_e'($urandom_range(3));
      case ($urandom_range(3))
        0:       level = 8'(8 * $urandom_range(29) + $urandom_range(1));  // on or one above a gray*8 step
        1:       level = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
        default: level = 8'($urandom);
      endcase
      apply_settings(mode, level);
      for (int n = 0; n < PHASE_PIXELS; n++) send_pixel(random_pixel(), 1'b0, 16'h0000);
    end

    settle_pipeline();
    repeat (20) @(posedge clk);

    $display("Covered %0d pixels (bypass %0d, gray %0d, threshold %0d, invert %0d),",
             pixels_sent, per_mode[rpp_pkg::MODE_BYPASS], per_mode[rpp_pkg::MODE_GRAY],
             per_mode[rpp_pkg::MODE_THRESHOLD], per_mode[rpp_pkg::MODE_INVERT]);
    $display("  %0d results checked, %0d register writes, %0d mismatches.",
             results_checked, reg_writes, error_count);
    if (error_count == 0) begin
      $display("rgb555_pixel_preprocess_test: clean");
    end else begin
      $display("rgb555_pixel_preprocess_test: errors");
    end
    $finish;
  end

endmodule
